// ----- sv/wls_pkg.sv -----
// Package: shared codes, widths and constants of the wireless link supervisor.
`timescale 1ns / 1ps

package wls_pkg;

    // Mode, one-hot inside the block
    typedef enum logic [4:0] {
        MODE_DISC   = 5'b00001,
        MODE_CONN   = 5'b00010,
        MODE_UP     = 5'b00100,
        MODE_FALTER = 5'b01000,
        MODE_DOWN   = 5'b10000
    } t_mode;

    // Mode codes as shown on the result word
    localparam logic [2:0] MODE_CODE_DISC   = 3'd0;
    localparam logic [2:0] MODE_CODE_CONN   = 3'd1;
    localparam logic [2:0] MODE_CODE_UP     = 3'd2;
    localparam logic [2:0] MODE_CODE_FALTER = 3'd3;
    localparam logic [2:0] MODE_CODE_DOWN   = 3'd4;

    // Commands
    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_CONNECT    = 2'd1;
    localparam logic [1:0] CMD_DISCONNECT = 2'd2;

    // Networks
    localparam logic [1:0] NET_NONE = 2'd0;
    localparam logic [1:0] NET_STA  = 2'd1;
    localparam logic [1:0] NET_AP   = 2'd2;

    // LED colors
    localparam logic [1:0] LED_OFF = 2'd0;
    localparam logic [1:0] LED_YEL = 2'd1;
    localparam logic [1:0] LED_GRN = 2'd2;

    // Service bit positions
    localparam int SVC_LINK = 0;
    localparam int SVC_DNS  = 1;
    localparam int SVC_SRV  = 2;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_JOIN_TIMEOUT   = 2'd0,
        REG_FALTER_TIMEOUT = 2'd1,
        REG_SETTLE         = 2'd2,
        REG_FAILURE_LIMIT  = 2'd3
    } t_reg_idx;

    // Register reset values
    localparam logic [19:0] JOIN_TIMEOUT_RST   = 20'd10000;
    localparam logic [19:0] FALTER_TIMEOUT_RST = 20'd10000;
    localparam logic [15:0] SETTLE_RST         = 16'd2000;
    localparam logic [3:0]  FAILURE_LIMIT_RST  = 4'd2;
    localparam logic [3:0]  FAIL_COUNT_RST     = 4'd2;
    localparam logic [3:0]  FAIL_COUNT_MAX     = 4'd15;

    // Blink periods and thresholds
    localparam logic [7:0]  DISC_PERIOD   = 8'd160;
    localparam logic [7:0]  DISC_SPLIT    = 8'd80;
    localparam logic [10:0] CONN_PERIOD   = 11'd1200;
    localparam logic [10:0] CONN_SPLIT    = 11'd600;
    localparam logic [8:0]  FALTER_PERIOD = 9'd400;
    localparam logic [8:0]  FALTER_SPLIT  = 9'd100;
    localparam logic [9:0]  DOWN_PERIOD   = 10'd800;
    localparam logic [9:0]  DOWN_SPLIT    = 10'd600;

    // One result word
    typedef struct packed {
        logic [2:0] mode_now;
        logic [1:0] led;
        logic       is_connected;
        logic [1:0] network_sel;
        logic       start_link;
        logic       start_dns;
        logic       start_srv;
        logic       stop_srv;
        logic       stop_dns;
        logic       stop_link;
        logic       cancel_join;
    } t_result;

endpackage

// ----- sv/wls_in_if.sv -----
// Interface: input channel of the wireless link supervisor.
`timescale 1ns / 1ps

interface wls_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [1:0] target_network;
    logic       link_up;
    logic       ip_up;
    logic       has_creds;

    modport source (
        output valid, cmd, target_network, link_up, ip_up, has_creds,
        input  ready
    );
    modport sink (
        input  valid, cmd, target_network, link_up, ip_up, has_creds,
        output ready
    );
endinterface

// ----- sv/wls_out_if.sv -----
// Interface: result channel of the wireless link supervisor.
`timescale 1ns / 1ps

interface wls_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode_now;
    logic [1:0] led;
    logic       is_connected;
    logic [1:0] network_sel;
    logic       start_link;
    logic       start_dns;
    logic       start_srv;
    logic       stop_srv;
    logic       stop_dns;
    logic       stop_link;
    logic       cancel_join;

    modport source (
        output valid, mode_now, led, is_connected, network_sel, start_link, start_dns,
               start_srv, stop_srv, stop_dns, stop_link, cancel_join,
        input  ready
    );
    modport sink (
        input  valid, mode_now, led, is_connected, network_sel, start_link, start_dns,
               start_srv, stop_srv, stop_dns, stop_link, cancel_join,
        output ready
    );
endinterface

// ----- sv/wifi_link_supervisor.sv -----
// Top level: wireless link supervisor with mode machine, timers and config port.
// The result word is registered at the edge that accepts the input word.
// Throughput: one word per cycle; input ready is high whenever the result register is
// empty or being emptied in the same cycle.
// Reset (i_rst_n low, synchronous): mode disconnected, timer and blink phases zero,
// no network, failure count 2, all services stopped, registers to defaults, result empty.
`timescale 1ns / 1ps

module wifi_link_supervisor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wls_in_if.sink       i_in,
    wls_out_if.source    o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // Configuration registers
    logic [19:0] r_join_to;
    logic [19:0] r_falter_to;
    logic [15:0] r_settle;
    logic [3:0]  r_limit;

    // Supervisor state
    wls_pkg::t_mode r_mode, n_mode;
    logic [31:0] r_timer, n_timer;
    logic [7:0]  r_ph_disc, n_ph_disc;
    logic [10:0] r_ph_conn, n_ph_conn;
    logic [8:0]  r_ph_falter, n_ph_falter;
    logic [9:0]  r_ph_down, n_ph_down;
    logic [1:0]  r_sel, n_sel;
    logic [1:0]  r_pend, n_pend;
    logic [3:0]  r_fail, n_fail;
    logic [2:0]  r_svc, n_svc;
    logic [1:0]  r_led, n_led;

    // Result register
    logic              r_out_valid;
    wls_pkg::t_result  r_out, n_out;

    logic accept;
    logic cfg_wr;

    // Blink phases of the incremented timer
    logic [31:0] t_inc;
    logic        t_wrap;
    logic [7:0]  ph_disc;
    logic [10:0] ph_conn;
    logic [8:0]  ph_falter;
    logic [9:0]  ph_down;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_join_to   <= wls_pkg::JOIN_TIMEOUT_RST;
            r_falter_to <= wls_pkg::FALTER_TIMEOUT_RST;
            r_settle    <= wls_pkg::SETTLE_RST;
            r_limit     <= wls_pkg::FAILURE_LIMIT_RST;
        end else if (cfg_wr) begin
            case (wls_pkg::t_reg_idx'(paddr[3:2]))
                wls_pkg::REG_JOIN_TIMEOUT:   r_join_to   <= pwdata[19:0];
                wls_pkg::REG_FALTER_TIMEOUT: r_falter_to <= pwdata[19:0];
                wls_pkg::REG_SETTLE:         r_settle    <= pwdata[15:0];
                wls_pkg::REG_FAILURE_LIMIT:  r_limit     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Config read
    always_comb begin
        case (wls_pkg::t_reg_idx'(paddr[3:2]))
            wls_pkg::REG_JOIN_TIMEOUT:   prdata = {12'd0, r_join_to};
            wls_pkg::REG_FALTER_TIMEOUT: prdata = {12'd0, r_falter_to};
            wls_pkg::REG_SETTLE:         prdata = {16'd0, r_settle};
            wls_pkg::REG_FAILURE_LIMIT:  prdata = {28'd0, r_limit};
            default:                     prdata = 32'd0;
        endcase
    end

    // Handshake: take a word whenever the result slot frees up
    assign i_in.ready = !r_out_valid || o_res.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Timer and phase counters one tick ahead; a timer wrap restarts every phase
    always_comb begin
        t_inc  = r_timer + 32'd1;
        t_wrap = (r_timer == 32'hFFFF_FFFF);
        ph_disc   = (t_wrap || r_ph_disc == wls_pkg::DISC_PERIOD - 8'd1) ? 8'd0
                    : r_ph_disc + 8'd1;
        ph_conn   = (t_wrap || r_ph_conn == wls_pkg::CONN_PERIOD - 11'd1) ? 11'd0
                    : r_ph_conn + 11'd1;
        ph_falter = (t_wrap || r_ph_falter == wls_pkg::FALTER_PERIOD - 9'd1) ? 9'd0
                    : r_ph_falter + 9'd1;
        ph_down   = (t_wrap || r_ph_down == wls_pkg::DOWN_PERIOD - 10'd1) ? 10'd0
                    : r_ph_down + 10'd1;
    end

    // Mode machine: one pass per accepted word
    always_comb begin
        logic       go_mode;
        logic [1:0] show;
        wls_pkg::t_mode tgt_mode;

        n_mode      = r_mode;
        n_timer     = r_timer;
        n_ph_disc   = r_ph_disc;
        n_ph_conn   = r_ph_conn;
        n_ph_falter = r_ph_falter;
        n_ph_down   = r_ph_down;
        n_sel       = r_sel;
        n_pend      = r_pend;
        n_fail      = r_fail;
        n_svc       = r_svc;
        n_led       = r_led;
        n_out       = '0;
        go_mode     = 1'b0;
        tgt_mode    = r_mode;
        show        = wls_pkg::LED_YEL;

        case (i_in.cmd)
            wls_pkg::CMD_TICK: begin
                n_timer     = t_inc;
                n_ph_disc   = ph_disc;
                n_ph_conn   = ph_conn;
                n_ph_falter = ph_falter;
                n_ph_down   = ph_down;
                case (r_mode)
                    wls_pkg::MODE_DISC: begin
                        n_led = (ph_disc < wls_pkg::DISC_SPLIT) ? wls_pkg::LED_YEL
                                : wls_pkg::LED_GRN;
                        if (!i_in.link_up && t_inc > {16'd0, r_settle}) begin
                            if (n_pend == wls_pkg::NET_NONE) begin
                                n_pend = wls_pkg::NET_AP;
                            end
                            n_sel = n_pend;
                            if (!n_svc[wls_pkg::SVC_LINK]) begin
                                if (!i_in.has_creds) begin
                                    n_sel = wls_pkg::NET_AP;
                                end
                                n_out.start_link = 1'b1;
                                n_svc[wls_pkg::SVC_LINK] = 1'b1;
                            end
                            go_mode  = 1'b1;
                            tgt_mode = wls_pkg::MODE_CONN;
                        end
                    end
                    wls_pkg::MODE_CONN: begin
                        show  = (n_sel == wls_pkg::NET_STA) ? wls_pkg::LED_GRN
                                : wls_pkg::LED_YEL;
                        n_led = (ph_conn < wls_pkg::CONN_SPLIT) ? wls_pkg::LED_OFF : show;
                        if (i_in.ip_up) begin
                            n_fail = 4'd0;
                            if (n_sel == wls_pkg::NET_AP && !n_svc[wls_pkg::SVC_DNS]) begin
                                n_out.start_dns = 1'b1;
                                n_svc[wls_pkg::SVC_DNS] = 1'b1;
                            end
                            if (!n_svc[wls_pkg::SVC_SRV]) begin
                                n_out.start_srv = 1'b1;
                                n_svc[wls_pkg::SVC_SRV] = 1'b1;
                            end
                            go_mode  = 1'b1;
                            tgt_mode = wls_pkg::MODE_UP;
                        end else if (t_inc > {12'd0, r_join_to}) begin
                            if (n_fail < wls_pkg::FAIL_COUNT_MAX) begin
                                n_fail = n_fail + 4'd1;
                            end
                            if (n_fail > r_limit) begin
                                // fall back to access point unless already there
                                if (n_sel != wls_pkg::NET_AP) begin
                                    n_out.cancel_join = 1'b1;
                                    go_mode  = 1'b1;
                                    tgt_mode = wls_pkg::MODE_DOWN;
                                    n_pend   = wls_pkg::NET_AP;
                                end
                            end else begin
                                n_out.cancel_join = 1'b1;
                                go_mode  = 1'b1;
                                tgt_mode = wls_pkg::MODE_DOWN;
                            end
                        end
                    end
                    wls_pkg::MODE_UP: begin
                        n_out.is_connected = i_in.ip_up;
                        if (!i_in.ip_up) begin
                            go_mode  = 1'b1;
                            tgt_mode = wls_pkg::MODE_FALTER;
                        end
                    end
                    wls_pkg::MODE_FALTER: begin
                        n_out.is_connected = i_in.ip_up;
                        show = (n_sel == wls_pkg::NET_STA) ? wls_pkg::LED_GRN
                               : wls_pkg::LED_YEL;
                        if (i_in.ip_up) begin
                            go_mode  = 1'b1;
                            tgt_mode = wls_pkg::MODE_UP;
                        end else if (t_inc > {12'd0, r_falter_to}) begin
                            go_mode  = 1'b1;
                            tgt_mode = wls_pkg::MODE_DOWN;
                        end else begin
                            n_led = (ph_falter < wls_pkg::FALTER_SPLIT) ? wls_pkg::LED_OFF
                                    : show;
                        end
                    end
                    wls_pkg::MODE_DOWN: begin
                        show  = (n_sel == wls_pkg::NET_STA) ? wls_pkg::LED_GRN
                                : wls_pkg::LED_YEL;
                        n_led = (ph_down < wls_pkg::DOWN_SPLIT) ? wls_pkg::LED_OFF : show;
                        if (t_inc > {16'd0, r_settle}) begin
                            n_out.stop_srv  = n_svc[wls_pkg::SVC_SRV];
                            n_out.stop_dns  = n_svc[wls_pkg::SVC_DNS];
                            n_out.stop_link = n_svc[wls_pkg::SVC_LINK];
                            n_svc    = 3'd0;
                            go_mode  = 1'b1;
                            tgt_mode = wls_pkg::MODE_DISC;
                        end
                    end
                    default: ;
                endcase
            end
            wls_pkg::CMD_CONNECT: begin
                if ((i_in.target_network == wls_pkg::NET_STA ||
                     i_in.target_network == wls_pkg::NET_AP) &&
                    r_sel != i_in.target_network) begin
                    n_out.cancel_join = (r_mode == wls_pkg::MODE_CONN);
                    go_mode  = 1'b1;
                    tgt_mode = wls_pkg::MODE_DOWN;
                    n_pend   = i_in.target_network;
                end
            end
            wls_pkg::CMD_DISCONNECT: begin
                go_mode  = 1'b1;
                tgt_mode = wls_pkg::MODE_DOWN;
            end
            default: ;
        endcase

        // Mode change restarts timer, phases and LED
        if (go_mode) begin
            n_mode      = tgt_mode;
            n_timer     = 32'd0;
            n_ph_disc   = 8'd0;
            n_ph_conn   = 11'd0;
            n_ph_falter = 9'd0;
            n_ph_down   = 10'd0;
            n_led       = wls_pkg::LED_OFF;
            // entering connected from a tick shows the network at once
            if (i_in.cmd == wls_pkg::CMD_TICK && tgt_mode == wls_pkg::MODE_UP) begin
                n_led = (n_sel == wls_pkg::NET_STA) ? wls_pkg::LED_GRN : wls_pkg::LED_YEL;
            end
        end

        case (n_mode)
            wls_pkg::MODE_DISC:   n_out.mode_now = wls_pkg::MODE_CODE_DISC;
            wls_pkg::MODE_CONN:   n_out.mode_now = wls_pkg::MODE_CODE_CONN;
            wls_pkg::MODE_UP:     n_out.mode_now = wls_pkg::MODE_CODE_UP;
            wls_pkg::MODE_FALTER: n_out.mode_now = wls_pkg::MODE_CODE_FALTER;
            wls_pkg::MODE_DOWN:   n_out.mode_now = wls_pkg::MODE_CODE_DOWN;
            default:              n_out.mode_now = wls_pkg::MODE_CODE_DISC;
        endcase
        n_out.led         = n_led;
        n_out.network_sel = n_sel;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= wls_pkg::MODE_DISC;
            r_timer     <= 32'd0;
            r_ph_disc   <= 8'd0;
            r_ph_conn   <= 11'd0;
            r_ph_falter <= 9'd0;
            r_ph_down   <= 10'd0;
            r_sel       <= wls_pkg::NET_NONE;
            r_pend      <= wls_pkg::NET_NONE;
            r_fail      <= wls_pkg::FAIL_COUNT_RST;
            r_svc       <= 3'd0;
            r_led       <= wls_pkg::LED_OFF;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_timer     <= n_timer;
            r_ph_disc   <= n_ph_disc;
            r_ph_conn   <= n_ph_conn;
            r_ph_falter <= n_ph_falter;
            r_ph_down   <= n_ph_down;
            r_sel       <= n_sel;
            r_pend      <= n_pend;
            r_fail      <= n_fail;
            r_svc       <= n_svc;
            r_led       <= n_led;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.mode_now     = r_out.mode_now;
    assign o_res.led          = r_out.led;
    assign o_res.is_connected = r_out.is_connected;
    assign o_res.network_sel  = r_out.network_sel;
    assign o_res.start_link   = r_out.start_link;
    assign o_res.start_dns    = r_out.start_dns;
    assign o_res.start_srv    = r_out.start_srv;
    assign o_res.stop_srv     = r_out.stop_srv;
    assign o_res.stop_dns     = r_out.stop_dns;
    assign o_res.stop_link    = r_out.stop_link;
    assign o_res.cancel_join  = r_out.cancel_join;

endmodule

// ----- sv/wls_checker.sv -----
// Checker: port-level assertions on the wireless link supervisor, with its bind.
`timescale 1ns / 1ps

module wls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_mode_now,
    input logic [1:0] i_led,
    input logic [1:0] i_network_sel,
    input logic       i_start_link,
    input logic       i_start_srv,
    input logic       i_stop_srv,
    input logic       i_stop_dns,
    input logic       i_stop_link,
    input logic       i_cancel_join
);

    // A stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
        $stable({i_mode_now, i_led, i_network_sel, i_start_link, i_start_srv,
                 i_stop_srv, i_stop_dns, i_stop_link, i_cancel_join}))
        else $error("result word changed while stalled");

    // A cancelled join always lands in disconnecting
    a_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_cancel_join |-> i_mode_now == wls_pkg::MODE_CODE_DOWN)
        else $error("cancel strobe outside disconnecting");

    // Servers start only on entry to connected, with the LED lit
    a_srv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_start_srv |->
            i_mode_now == wls_pkg::MODE_CODE_UP && i_led != wls_pkg::LED_OFF)
        else $error("server start outside connected entry");

    // Stop strobes come only with the move to disconnected
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_stop_srv || i_stop_dns || i_stop_link) |->
            i_mode_now == wls_pkg::MODE_CODE_DISC)
        else $error("stop strobe outside disconnected entry");

    // Link start names a network
    a_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_start_link |->
            i_network_sel != wls_pkg::NET_NONE && i_mode_now == wls_pkg::MODE_CODE_CONN)
        else $error("link start without a selected network");

endmodule

bind wifi_link_supervisor wls_checker u_wls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_mode_now    (o_res.mode_now),
    .i_led         (o_res.led),
    .i_network_sel (o_res.network_sel),
    .i_start_link  (o_res.start_link),
    .i_start_srv   (o_res.start_srv),
    .i_stop_srv    (o_res.stop_srv),
    .i_stop_dns    (o_res.stop_dns),
    .i_stop_link   (o_res.stop_link),
    .i_cancel_join (o_res.cancel_join)
);

// ----- test/wifi_link_supervisor_tb.sv -----
// Testbench: link supervisor driven with directed and random words, checked against a predictor.
`timescale 1ns / 1ps

module wifi_link_supervisor_tb;

    // Codes the package leaves out: the unused command and an invalid target
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] NET_BAD    = 2'd3;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wls_in_if  in_ch ();
    wls_out_if res_ch ();

    wifi_link_supervisor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted supervisor state and register copies
    logic [2:0]  sup_mode;
    logic [31:0] sup_timer;
    logic [1:0]  sup_net;
    logic [1:0]  sup_pend;
    logic [3:0]  sup_fails;
    logic [2:0]  sup_svc;
    logic [1:0]  sup_led;
    logic [19:0] cfg_join;
    logic [19:0] cfg_falter;
    logic [15:0] cfg_settle;
    logic [3:0]  cfg_limit;
    wls_pkg::t_result next_word;

    wls_pkg::t_result expected_words[$];
    int          err_cnt;
    int          burst_left;
    int          hold_requests;
    int          holds_done;
    int          stall_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic void go_mode(logic [2:0] m);
        sup_mode  = m;
        sup_timer = '0;
        sup_led   = wls_pkg::LED_OFF;
    endfunction

    function automatic void show_net();
        sup_led = (sup_net == wls_pkg::NET_STA) ? wls_pkg::LED_GRN : wls_pkg::LED_YEL;
    endfunction

    // start fires only for a stopped service; link without credentials forces AP
    function automatic void start_svc(int b, logic creds);
        if (sup_svc[b])
            return;
        if (b == wls_pkg::SVC_LINK && !creds)
            sup_net = wls_pkg::NET_AP;
        sup_svc[b] = 1'b1;
        case (b)
            wls_pkg::SVC_LINK: next_word.start_link = 1'b1;
            wls_pkg::SVC_DNS:  next_word.start_dns  = 1'b1;
            default:           next_word.start_srv  = 1'b1;
        endcase
    endfunction

    function automatic void stop_svc(int b);
        if (!sup_svc[b])
            return;
        sup_svc[b] = 1'b0;
        case (b)
            wls_pkg::SVC_LINK: next_word.stop_link = 1'b1;
            wls_pkg::SVC_DNS:  next_word.stop_dns  = 1'b1;
            default:           next_word.stop_srv  = 1'b1;
        endcase
    endfunction

    function automatic void abort_join();
        next_word.cancel_join = 1'b1;
        go_mode(wls_pkg::MODE_CODE_DOWN);
    endfunction

    // a request for the network already selected changes nothing
    function automatic void request_net(logic [1:0] netw);
        if (sup_net != netw) begin
            if (sup_mode == wls_pkg::MODE_CODE_CONN)
                abort_join();
            go_mode(wls_pkg::MODE_CODE_DOWN);
            sup_pend = netw;
        end
    endfunction

    function automatic wls_pkg::t_result supervise(logic [1:0] cmd, logic [1:0] tgt,
                                                   logic link, logic ip, logic creds);
        logic [31:0] t;
        logic        up;
        next_word = '0;
        up        = 1'b0;
        case (cmd)
            wls_pkg::CMD_TICK: begin
                sup_timer = sup_timer + 32'd1;
                t         = sup_timer;
                case (sup_mode)
                    wls_pkg::MODE_CODE_DISC: begin
                        sup_led = ((t % wls_pkg::DISC_PERIOD) < wls_pkg::DISC_SPLIT)
                                  ? wls_pkg::LED_YEL : wls_pkg::LED_GRN;
                        if (!link && t > cfg_settle) begin
                            if (sup_pend == wls_pkg::NET_NONE)
                                sup_pend = wls_pkg::NET_AP;
                            sup_net = sup_pend;
                            start_svc(wls_pkg::SVC_LINK, creds);
                            go_mode(wls_pkg::MODE_CODE_CONN);
                        end
                    end
                    wls_pkg::MODE_CODE_CONN: begin
                        if ((t % wls_pkg::CONN_PERIOD) < wls_pkg::CONN_SPLIT)
                            sup_led = wls_pkg::LED_OFF;
                        else
                            show_net();
                        if (ip) begin
                            sup_fails = '0;
                            if (sup_net == wls_pkg::NET_AP)
                                start_svc(wls_pkg::SVC_DNS, creds);
                            start_svc(wls_pkg::SVC_SRV, creds);
                            go_mode(wls_pkg::MODE_CODE_UP);
                            show_net();
                        end else if (t > cfg_join) begin
                            if (sup_fails < wls_pkg::FAIL_COUNT_MAX)
                                sup_fails = sup_fails + 4'd1;
                            if (sup_fails > cfg_limit)
                                request_net(wls_pkg::NET_AP);
                            else
                                abort_join();
                        end
                    end
                    wls_pkg::MODE_CODE_UP: begin
                        up = ip;
                        if (!ip)
                            go_mode(wls_pkg::MODE_CODE_FALTER);
                    end
                    wls_pkg::MODE_CODE_FALTER: begin
                        up = ip;
                        if (ip) begin
                            go_mode(wls_pkg::MODE_CODE_UP);
                            show_net();
                        end else if (t > cfg_falter) begin
                            go_mode(wls_pkg::MODE_CODE_DOWN);
                        end else if ((t % wls_pkg::FALTER_PERIOD) < wls_pkg::FALTER_SPLIT) begin
                            sup_led = wls_pkg::LED_OFF;
                        end else begin
                            show_net();
                        end
                    end
                    wls_pkg::MODE_CODE_DOWN: begin
                        if ((t % wls_pkg::DOWN_PERIOD) < wls_pkg::DOWN_SPLIT)
                            sup_led = wls_pkg::LED_OFF;
                        else
                            show_net();
                        if (t > cfg_settle) begin
                            stop_svc(wls_pkg::SVC_SRV);
                            stop_svc(wls_pkg::SVC_DNS);
                            stop_svc(wls_pkg::SVC_LINK);
                            go_mode(wls_pkg::MODE_CODE_DISC);
                        end
                    end
                    default: ;
                endcase
            end
            wls_pkg::CMD_CONNECT: begin
                if (tgt == wls_pkg::NET_STA || tgt == wls_pkg::NET_AP)
                    request_net(tgt);
            end
            wls_pkg::CMD_DISCONNECT: go_mode(wls_pkg::MODE_CODE_DOWN);
            default: ;
        endcase
        next_word.mode_now     = sup_mode;
        next_word.led          = sup_led;
        next_word.is_connected = up;
        next_word.network_sel  = sup_net;
        return next_word;
    endfunction

    task automatic reset_predictor();
        sup_mode   = wls_pkg::MODE_CODE_DISC;
        sup_timer  = '0;
        sup_net    = wls_pkg::NET_NONE;
        sup_pend   = wls_pkg::NET_NONE;
        sup_fails  = wls_pkg::FAIL_COUNT_RST;
        sup_svc    = '0;
        sup_led    = wls_pkg::LED_OFF;
        cfg_join   = wls_pkg::JOIN_TIMEOUT_RST;
        cfg_falter = wls_pkg::FALTER_TIMEOUT_RST;
        cfg_settle = wls_pkg::SETTLE_RST;
        cfg_limit  = wls_pkg::FAILURE_LIMIT_RST;
    endtask

    // ---------------- drivers ----------------

    // Offer one word, wait for it to be taken, then record its expected result
    task automatic send_word(input logic [1:0] cmd, input logic [1:0] tgt,
                             input logic link, input logic ip, input logic creds);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
            gap = 0;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.cmd            = cmd;
        in_ch.target_network = tgt;
        in_ch.link_up        = link;
        in_ch.ip_up          = ip;
        in_ch.has_creds      = creds;
        in_ch.valid          = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        expected_words.push_back(supervise(cmd, tgt, link, ip, creds));
        burst_left--;
    endtask

    // Stop offering and wait for every expected word to come back
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_cycle(input logic wr, input wls_pkg::t_reg_idx idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Write a register, mirror it in the predictor, read it back
    task automatic write_reg(input wls_pkg::t_reg_idx idx, input logic [31:0] val);
        logic [31:0] rd;
        apb_cycle(1'b1, idx, val, rd);
        case (idx)
            wls_pkg::REG_JOIN_TIMEOUT:   cfg_join   = val[19:0];
            wls_pkg::REG_FALTER_TIMEOUT: cfg_falter = val[19:0];
            wls_pkg::REG_SETTLE:         cfg_settle = val[15:0];
            default:                     cfg_limit  = val[3:0];
        endcase
        apb_cycle(1'b0, idx, '0, rd);
        if (rd !== val) begin
            $error("register %s: expected %0d, actual %0d", idx.name(), val, rd);
            err_cnt++;
        end
    endtask

    task automatic set_regs(input int join_ms, input int falter_ms, input int settle,
                            input int limit);
        drain();
        write_reg(wls_pkg::REG_JOIN_TIMEOUT, join_ms);
        write_reg(wls_pkg::REG_FALTER_TIMEOUT, falter_ms);
        write_reg(wls_pkg::REG_SETTLE, settle);
        write_reg(wls_pkg::REG_FAILURE_LIMIT, limit);
    endtask

    // Random words shaped by the predicted mode: ip is held low for a while in
    // connecting and faltering so the long blink phases and timeouts are reached
    task automatic run_random(input int n, input int req_pm, input int conn_hold,
                              input int conn_ip_pm, input int up_ip_pm,
                              input int fal_hold, input int fal_ip_pm, input int hold_at);
        logic [1:0] cmd;
        logic [1:0] tgt;
        logic       link;
        logic       ip;
        logic       creds;
        int         k;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at)
                hold_requests++;
            creds = ($urandom_range(0, 3) != 0);
            tgt   = 2'($urandom_range(0, 3));
            link  = 1'($urandom_range(0, 1));
            ip    = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 49) == 0) begin
                cmd = 2'($urandom_range(0, 3));
            end else if ($urandom_range(0, 999) < req_pm) begin
                k   = $urandom_range(0, 19);
                cmd = (k < 13) ? wls_pkg::CMD_CONNECT
                      : (k < 19) ? wls_pkg::CMD_DISCONNECT : CMD_UNUSED;
                if ($urandom_range(0, 9) == 0)
                    tgt = $urandom_range(0, 1) ? wls_pkg::NET_NONE : NET_BAD;
                else
                    tgt = $urandom_range(0, 1) ? wls_pkg::NET_STA : wls_pkg::NET_AP;
            end else begin
                cmd = wls_pkg::CMD_TICK;
                case (sup_mode)
                    wls_pkg::MODE_CODE_DISC:   link = ($urandom_range(0, 4) == 0);
                    wls_pkg::MODE_CODE_CONN:   ip = (sup_timer >= conn_hold) &&
                                                    ($urandom_range(0, 999) < conn_ip_pm);
                    wls_pkg::MODE_CODE_UP:     ip = ($urandom_range(0, 999) < up_ip_pm);
                    wls_pkg::MODE_CODE_FALTER: ip = (sup_timer >= fal_hold) &&
                                                    ($urandom_range(0, 999) < fal_ip_pm);
                    default: ;
                endcase
            end
            send_word(cmd, tgt, link, ip, creds);
        end
    endtask

    // ---------------- tests ----------------

    // Reset values; ignored commands and targets; requests from disconnected
    task automatic test_reset_defaults();
        send_word(wls_pkg::CMD_TICK, NET_BAD, 1'b1, 1'b1, 1'b1);
        send_word(CMD_UNUSED, NET_BAD, 1'b1, 1'b1, 1'b1);
        send_word(wls_pkg::CMD_CONNECT, wls_pkg::NET_NONE, 1'b0, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_CONNECT, NET_BAD, 1'b0, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_CONNECT, wls_pkg::NET_STA, 1'b0, 1'b0, 1'b1);
        send_word(wls_pkg::CMD_CONNECT, wls_pkg::NET_STA, 1'b1, 1'b1, 1'b1);
        send_word(wls_pkg::CMD_DISCONNECT, wls_pkg::NET_AP, 1'b0, 1'b1, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b0, 1'b0, 1'b0);
    endtask

    // Minimum timeouts: full walk through every mode without credentials,
    // including repeated failure with access point already selected
    task automatic test_fast_walk();
        set_regs(1, 1, 1, 0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b0, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b0, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b0, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b0, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b1, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b1, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b1, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_TICK, wls_pkg::NET_NONE, 1'b1, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_CONNECT, wls_pkg::NET_AP, 1'b0, 1'b0, 1'b0);
        send_word(wls_pkg::CMD_CONNECT, wls_pkg::NET_STA, 1'b0, 1'b0, 1'b1);
    endtask

    // Short timeouts, frequent requests; the receiver holds off once mid-run
    task automatic test_churn();
        set_regs(12, 10, 4, 2);
        run_random(500, 60, 0, 100, 850, 0, 300, 250);
    endtask

    // Long connecting and faltering dwells to reach the late blink phases
    task automatic test_long_blink();
        set_regs(650, 130, 1, 0);
        run_random(700, 2, 610, 500, 970, 110, 30, -1);
    endtask

    // Long settle time: late disconnecting blink and both disconnected colors
    task automatic test_long_settle();
        set_regs(3, 3, 620, 15);
        send_word(wls_pkg::CMD_DISCONNECT, wls_pkg::NET_STA, 1'b0, 1'b0, 1'b1);
        run_random(700, 1, 0, 200, 900, 0, 300, -1);
    endtask

    // Large register values: settle time and failure limit at their maxima
    task automatic test_extremes();
        set_regs(600000, 600000, 65535, 15);
        run_random(30, 100, 0, 50, 900, 0, 300, -1);
    endtask

    // ---------------- result checking ----------------

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    initial begin
        wls_pkg::t_result exp_w;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no expectation waiting");
                    err_cnt++;
                end else begin
                    exp_w = expected_words.pop_front();
                    check_field("mode_now", 32'(exp_w.mode_now), 32'(res_ch.mode_now));
                    check_field("led", 32'(exp_w.led), 32'(res_ch.led));
                    check_field("is_connected", 32'(exp_w.is_connected),
                                32'(res_ch.is_connected));
                    check_field("network_sel", 32'(exp_w.network_sel),
                                32'(res_ch.network_sel));
                    check_field("start_link", 32'(exp_w.start_link), 32'(res_ch.start_link));
                    check_field("start_dns", 32'(exp_w.start_dns), 32'(res_ch.start_dns));
                    check_field("start_srv", 32'(exp_w.start_srv), 32'(res_ch.start_srv));
                    check_field("stop_srv", 32'(exp_w.stop_srv), 32'(res_ch.stop_srv));
                    check_field("stop_dns", 32'(exp_w.stop_dns), 32'(res_ch.stop_dns));
                    check_field("stop_link", 32'(exp_w.stop_link), 32'(res_ch.stop_link));
                    check_field("cancel_join", 32'(exp_w.cancel_join),
                                32'(res_ch.cancel_join));
                end
            end
        end
    end

    // Receiver: stall style is redrawn after a random run; long hold on request
    initial begin
        int style;
        int style_left;
        int long_left;
        int rx_cycle;
        logic rdy;
        res_ch.ready = 1'b0;
        style      = 0;
        style_left = 0;
        long_left  = 0;
        rx_cycle   = 0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                long_left  = LONG_HOLD;
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(20, 150);
            end
            style_left--;
            if (long_left > 0) begin
                long_left--;
                rdy = 1'b0;
            end else begin
                case (style)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = (rx_cycle % 5 != 0);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            res_ch.ready = rdy;
            rx_cycle++;
        end
    end

    // Watchdog: cycles in a row with no word moving on either side
    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------- main sequence ----------------
    initial begin
        err_cnt              = 0;
        burst_left           = 0;
        hold_requests        = 0;
        holds_done           = 0;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.cmd            = wls_pkg::CMD_TICK;
        in_ch.target_network = wls_pkg::NET_NONE;
        in_ch.link_up        = 1'b0;
        in_ch.ip_up          = 1'b0;
        in_ch.has_creds      = 1'b0;
        reset_predictor();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_fast_walk();
        test_churn();
        test_long_blink();
        test_long_settle();
        test_extremes();

        drain();
        repeat (4) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
